// ----- src/skt_pkg.sv -----
package skt_pkg;

	// Field widths of one table entry.
	localparam int KEY_W = 16;
	localparam int PAY_W = 32;

	// Command codes carried on the input tuser.
	typedef logic [2:0] cmd_t;
	localparam cmd_t CMD_INSERT    = 3'd0;
	localparam cmd_t CMD_SEARCH    = 3'd1;
	localparam cmd_t CMD_DELETE    = 3'd2;
	localparam cmd_t CMD_LIST_ASC  = 3'd3;
	localparam cmd_t CMD_LIST_DESC = 3'd4;

	// Status codes carried on the output tuser.
	typedef logic [1:0] status_t;
	localparam status_t STAT_OK    = 2'd0;
	localparam status_t STAT_MISS  = 2'd1;
	localparam status_t STAT_EMPTY = 2'd2;
	localparam status_t STAT_FULL  = 2'd3;

	// Contents of one cell of the chain.
	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} entry_t;

	// What every cell does in a cycle.
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_DELETE,
		CELL_ROT_L,
		CELL_ROT_R
	} cell_op_t;

	// Broadcast from the controller to all cells.
	typedef struct packed {
		cell_op_t         op;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} cell_ctrl_t;

endpackage

// ----- src/skt_cell.sv -----
module skt_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  skt_pkg::cell_ctrl_t ctrl,
	input  skt_pkg::entry_t     left,
	input  logic                left_ge,
	input  skt_pkg::entry_t     right,
	output skt_pkg::entry_t     ent,
	output logic                ge
);

	logic                      valid_q;
	logic [skt_pkg::KEY_W-1:0] key_q;
	logic [skt_pkg::PAY_W-1:0] payload_q;
	skt_pkg::entry_t           nxt;

	assign ent = '{valid: valid_q, key: key_q, payload: payload_q};

	// The broadcast key goes at or ahead of this entry.
	assign ge = valid_q && (ctrl.key <= key_q);

	// Next contents: keep, take the new entry, or take a neighbour's.
	always_comb begin
		nxt = ent;
		unique case (ctrl.op)
			skt_pkg::CELL_HOLD: begin
			end
			skt_pkg::CELL_INSERT: begin
				if (left_ge) begin
					nxt = left;
				end else if (ge || (!valid_q && left.valid)) begin
					nxt = '{valid: 1'b1, key: ctrl.key, payload: ctrl.payload};
				end
			end
			skt_pkg::CELL_DELETE: begin
				if (ge) begin
					nxt = right;
				end
			end
			skt_pkg::CELL_ROT_L: nxt = right;
			skt_pkg::CELL_ROT_R: nxt = left;
			default: nxt = ent;
		endcase
	end

	// Occupancy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	// Entry contents.
	always_ff @(posedge clk) begin
		key_q     <= nxt.key;
		payload_q <= nxt.payload;
	end

endmodule

// ----- src/sorted_key_table_core.sv -----
// Sorted key table: up to DEPTH entries of a 16-bit key and a 32-bit payload,
// held in a chain of cells in ascending key order.
// Input channel s_axis: one word per command; tuser carries the command,
// tdata the key and the payload. Output channel m_axis: result words; tuser
// carries the status, tdata the key and payload reported, tlast the final word.
// Insert updates the chain at acceptance and its result appears in the cycle
// after acceptance. Search and delete rotate the whole chain once past cell 0,
// then report, and a delete closes the gap, once the output register is free.
// A list rotates the chain once, one step per cycle while the output register
// can take a word; empty-table, full-table and unknown commands end at
// acceptance. A new command is accepted only while the controller is idle
// and the output register is free or being emptied. When the receiver
// stalls, a list rotation halts and a search or delete waits before its
// report, with the word held, and nothing is lost.
// Reset clears all cells to empty, the entry count and the output valid flag;
// no clearing pass is needed.
module sorted_key_table_core #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // key [15:0], payload [47:16]
	input  logic [2:0]  s_axis_tuser,  // command [2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // key_out [15:0], payload_out [47:16]
	output logic [1:0]  m_axis_tuser,  // status [1:0]
	output logic        m_axis_tlast
);

	localparam int KW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [KW-1:0] K_LAST = KW'(DEPTH - 1);
	localparam logic [CW-1:0] C_FULL = CW'(DEPTH);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FIN, ST_LIST} state_t;

	state_t                    state_q;
	skt_pkg::cmd_t             cmd_q;
	logic [skt_pkg::KEY_W-1:0] key_q;
	logic [skt_pkg::KEY_W-1:0] fkey_q;
	logic [skt_pkg::PAY_W-1:0] fpay_q;
	logic                      found_q;
	logic [KW-1:0]             k_q;
	logic [CW-1:0]             count_q;
	logic                      m_valid_q;
	logic [47:0]               m_data_q;
	logic [1:0]                m_user_q;
	logic                      m_last_q;

	skt_pkg::cmd_t             in_cmd;
	logic [skt_pkg::KEY_W-1:0] in_key;
	logic [skt_pkg::PAY_W-1:0] in_pay;
	logic                      out_free;
	logic                      accept;
	logic                      list_asc;
	logic                      list_last;
	skt_pkg::entry_t           view;
	skt_pkg::cell_ctrl_t       ctrl;
	skt_pkg::entry_t           ent [DEPTH];
	logic                      ge [DEPTH];
	skt_pkg::entry_t           left_bound;
	skt_pkg::entry_t           right_bound;
	logic [DEPTH-1:0]          valid_vec;

	assign in_cmd = s_axis_tuser;
	assign in_key = s_axis_tdata[15:0];
	assign in_pay = s_axis_tdata[47:16];

	// Handshakes.
	assign out_free      = !m_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && out_free;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;
	assign m_axis_tlast  = m_last_q;

	// Readout position and final-word test for a list.
	assign list_asc  = (cmd_q == skt_pkg::CMD_LIST_ASC);
	assign view      = list_asc ? ent[0] : ent[DEPTH-1];
	assign list_last = list_asc ? (CW'(k_q) == (count_q - 1'b1)) : (k_q == K_LAST);

	// Operation broadcast to the chain.
	always_comb begin
		ctrl.op      = skt_pkg::CELL_HOLD;
		ctrl.key     = (state_q == ST_IDLE) ? in_key : key_q;
		ctrl.payload = in_pay;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && in_cmd == skt_pkg::CMD_INSERT && count_q != C_FULL) begin
					ctrl.op = skt_pkg::CELL_INSERT;
				end
			end
			ST_SCAN: ctrl.op = skt_pkg::CELL_ROT_L;
			ST_FIN: begin
				if (out_free && found_q && cmd_q == skt_pkg::CMD_DELETE) begin
					ctrl.op = skt_pkg::CELL_DELETE;
				end
			end
			ST_LIST: begin
				if (out_free) begin
					ctrl.op = list_asc ? skt_pkg::CELL_ROT_L : skt_pkg::CELL_ROT_R;
				end
			end
			default: ctrl.op = skt_pkg::CELL_HOLD;
		endcase
	end

	// Ends of the chain close into a ring when rotating.
	always_comb begin
		left_bound  = '{valid: 1'b1, key: '0, payload: '0};
		right_bound = '{valid: 1'b0, key: '0, payload: '0};
		if (ctrl.op == skt_pkg::CELL_ROT_R) begin
			left_bound = ent[DEPTH-1];
		end
		if (ctrl.op == skt_pkg::CELL_ROT_L) begin
			right_bound = ent[0];
		end
	end

	// The chain of cells.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		skt_pkg::entry_t l_ent;
		skt_pkg::entry_t r_ent;
		logic            l_ge;

		if (i == 0) begin : g_first
			assign l_ent = left_bound;
			assign l_ge  = 1'b0;
		end else begin : g_mid
			assign l_ent = ent[i-1];
			assign l_ge  = ge[i-1];
		end

		if (i == DEPTH - 1) begin : g_end
			assign r_ent = right_bound;
		end else begin : g_inner
			assign r_ent = ent[i+1];
		end

		skt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.left    (l_ent),
			.left_ge (l_ge),
			.right   (r_ent),
			.ent     (ent[i]),
			.ge      (ge[i])
		);

		assign valid_vec[i] = ent[i].valid;
	end

	// Controller with the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cmd_q     <= skt_pkg::CMD_INSERT;
			key_q     <= '0;
			fkey_q    <= '0;
			fpay_q    <= '0;
			found_q   <= 1'b0;
			k_q       <= '0;
			count_q   <= '0;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
			m_user_q  <= skt_pkg::STAT_OK;
			m_last_q  <= 1'b0;
		end else begin
			if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q   <= in_cmd;
						key_q   <= in_key;
						k_q     <= '0;
						found_q <= 1'b0;
						unique case (in_cmd)
							skt_pkg::CMD_INSERT: begin
								m_valid_q <= 1'b1;
								m_last_q  <= 1'b1;
								if (count_q == C_FULL) begin
									m_user_q <= skt_pkg::STAT_FULL;
									m_data_q <= '0;
								end else begin
									count_q  <= count_q + 1'b1;
									m_user_q <= skt_pkg::STAT_OK;
									m_data_q <= {in_pay, in_key};
								end
							end
							skt_pkg::CMD_SEARCH, skt_pkg::CMD_DELETE,
							skt_pkg::CMD_LIST_ASC, skt_pkg::CMD_LIST_DESC: begin
								if (count_q == '0) begin
									m_valid_q <= 1'b1;
									m_last_q  <= 1'b1;
									m_user_q  <= skt_pkg::STAT_EMPTY;
									m_data_q  <= '0;
								end else if (in_cmd == skt_pkg::CMD_SEARCH ||
								             in_cmd == skt_pkg::CMD_DELETE) begin
									state_q <= ST_SCAN;
								end else begin
									state_q <= ST_LIST;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					// Catch the first match as the ring passes cell 0.
					k_q <= k_q + 1'b1;
					if (!found_q && ent[0].valid && ent[0].key == key_q) begin
						found_q <= 1'b1;
						fkey_q  <= ent[0].key;
						fpay_q  <= ent[0].payload;
					end
					if (k_q == K_LAST) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_last_q  <= 1'b1;
						if (found_q) begin
							m_user_q <= skt_pkg::STAT_OK;
							m_data_q <= {fpay_q, fkey_q};
							if (cmd_q == skt_pkg::CMD_DELETE) begin
								count_q <= count_q - 1'b1;
							end
						end else begin
							m_user_q <= skt_pkg::STAT_MISS;
							m_data_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_LIST: begin
					// One word per step; empty cells pass by unreported.
					if (out_free) begin
						if (view.valid) begin
							m_valid_q <= 1'b1;
							m_last_q  <= list_last;
							m_user_q  <= skt_pkg::STAT_OK;
							m_data_q  <= {view.payload, view.key};
						end
						k_q <= k_q + 1'b1;
						if (k_q == K_LAST) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The entry count never exceeds the number of cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= C_FULL)
		else $error("entry count beyond table depth");

	// Between commands the count matches the occupied cells.
	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> ($countones(valid_vec) == count_q))
		else $error("entry count differs from occupied cells");

	// Between commands the occupied cells form an unbroken run from cell 0.
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> ((valid_vec & (valid_vec + 1'b1)) == '0))
		else $error("gap in the chain of occupied cells");

	// A search rotation runs for the whole ring before reporting.
	a_scan_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && k_q != K_LAST) |=> (state_q == ST_SCAN))
		else $error("search rotation ended early");

endmodule

// ----- tb/sorted_key_table_core_tb.sv -----
`timescale 1ns / 100ps

module sorted_key_table_core_tb;

	localparam int TABLE_DEPTH  = 16;
	localparam int RANDOM_ITEMS = 300;
	localparam int PHASE_ITEMS  = 30;
	localparam int HOLD_AT      = 120;
	localparam int HOLD_CYCLES  = 300;
	localparam int CALM_FROM    = 200;
	localparam int CALM_TO      = 260;
	localparam int STALL_LIMIT  = 4000;
	localparam int SETTLE_WAIT  = 4 * TABLE_DEPTH + 16;

	// Command codes the block does not decode; it must swallow them silently.
	localparam skt_pkg::cmd_t CMD_SPARE_A = 3'd5;
	localparam skt_pkg::cmd_t CMD_SPARE_B = 3'd6;
	localparam skt_pkg::cmd_t CMD_SPARE_C = 3'd7;

	typedef enum int {MODE_FILL, MODE_MIXED, MODE_DRAIN} traffic_mode_t;

	// One reply word as it leaves the output channel.
	typedef struct packed {
		skt_pkg::status_t          status;
		logic [skt_pkg::KEY_W-1:0] key;
		logic [skt_pkg::PAY_W-1:0] payload;
		logic                      last;
	} reply_word_t;

	// One line of the directed sequence; want is used only when typed is set.
	typedef struct packed {
		skt_pkg::cmd_t             cmd;
		logic [skt_pkg::KEY_W-1:0] key;
		logic [skt_pkg::PAY_W-1:0] payload;
		logic                      typed;
		reply_word_t               want;
	} directed_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic [2:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	// Shadow copy of the table contents, kept in ascending key order.
	logic [skt_pkg::KEY_W-1:0] table_keys[$];
	logic [skt_pkg::PAY_W-1:0] table_pays[$];

	reply_word_t awaited_replies[$];
	reply_word_t fresh_replies[$];
	int          accepted_cmds = 0;
	int          bad_words = 0;
	logic        calm;

	assign calm = (accepted_cmds >= CALM_FROM) && (accepted_cmds < CALM_TO);

	sorted_key_table_core #(
		.DEPTH(TABLE_DEPTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Work out the reply words of one command and update the shadow table.
	function automatic void apply_command(skt_pkg::cmd_t cmd,
			logic [skt_pkg::KEY_W-1:0] key, logic [skt_pkg::PAY_W-1:0] payload);
		int pos;
		int n;
		int idx;
		n = table_keys.size();
		fresh_replies.delete();
		case (cmd)
			skt_pkg::CMD_INSERT: begin
				if (n >= TABLE_DEPTH) begin
					fresh_replies.push_back('{skt_pkg::STAT_FULL, '0, '0, 1'b1});
				end else begin
					// The new entry goes ahead of any entries with an equal key.
					pos = 0;
					while (pos < n && key > table_keys[pos])
						pos++;
					table_keys.insert(pos, key);
					table_pays.insert(pos, payload);
					fresh_replies.push_back('{skt_pkg::STAT_OK, key, payload, 1'b1});
				end
			end
			skt_pkg::CMD_SEARCH, skt_pkg::CMD_DELETE: begin
				pos = 0;
				while (pos < n && table_keys[pos] != key)
					pos++;
				if (n == 0) begin
					fresh_replies.push_back('{skt_pkg::STAT_EMPTY, '0, '0, 1'b1});
				end else if (pos == n) begin
					fresh_replies.push_back('{skt_pkg::STAT_MISS, '0, '0, 1'b1});
				end else begin
					fresh_replies.push_back('{skt_pkg::STAT_OK, table_keys[pos],
						table_pays[pos], 1'b1});
					if (cmd == skt_pkg::CMD_DELETE) begin
						table_keys.delete(pos);
						table_pays.delete(pos);
					end
				end
			end
			skt_pkg::CMD_LIST_ASC, skt_pkg::CMD_LIST_DESC: begin
				if (n == 0) begin
					fresh_replies.push_back('{skt_pkg::STAT_EMPTY, '0, '0, 1'b1});
				end else begin
					for (int i = 0; i < n; i++) begin
						idx = (cmd == skt_pkg::CMD_LIST_ASC) ? i : n - 1 - i;
						fresh_replies.push_back('{skt_pkg::STAT_OK, table_keys[idx],
							table_pays[idx], logic'(i == n - 1)});
					end
				end
			end
			default: ;
		endcase
	endfunction

	// A key from the table if asked; else keys near the ends, or anything.
	function automatic logic [skt_pkg::KEY_W-1:0] pick_key(bit from_table);
		int sel;
		sel = $urandom_range(99);
		if (from_table && table_keys.size() != 0)
			return table_keys[$urandom_range(table_keys.size() - 1)];
		if (sel < 25)
			return skt_pkg::KEY_W'($urandom_range(3));
		if (sel < 40)
			return 16'hFFFF - skt_pkg::KEY_W'($urandom_range(3));
		return skt_pkg::KEY_W'($urandom());
	endfunction

	// Offer one command word, wait for it to be taken and record its replies.
	task automatic issue(skt_pkg::cmd_t cmd, logic [skt_pkg::KEY_W-1:0] key,
			logic [skt_pkg::PAY_W-1:0] payload, logic typed, reply_word_t want);
		int gap;
		gap = (!calm && $urandom_range(99) < 26) ? $urandom_range(1, 4) : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {payload, key};
		s_axis_tuser  <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		accepted_cmds++;
		apply_command(cmd, key, payload);
		if (typed) begin
			awaited_replies.push_back(want);
		end else begin
			foreach (fresh_replies[i])
				awaited_replies.push_back(fresh_replies[i]);
		end
	endtask

	// Output pacing: random stalls, one long hold-off and a calm stretch.
	initial begin : receiver_pacing
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!hold_done && accepted_cmds >= HOLD_AT) begin
				hold_done = 1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (calm) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= 26);
			end
		end
	end

	// Compare every word taken from the output with the oldest expectation.
	always @(posedge clk) begin : reply_check
		reply_word_t got;
		reply_word_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[47:16], m_axis_tlast};
			if (awaited_replies.size() == 0) begin
				$display("%0t: unexpected word status=%0d key=%h payload=%h last=%b",
					$time, got.status, got.key, got.payload, got.last);
				bad_words++;
			end else begin
				want = awaited_replies.pop_front();
				if (got.status !== want.status || got.key !== want.key ||
						got.payload !== want.payload || got.last !== want.last) begin
					$display("%0t: mismatch expected status=%0d key=%h payload=%h last=%b",
						$time, want.status, want.key, want.payload, want.last);
					$display("%0t:          actual   status=%0d key=%h payload=%h last=%b",
						$time, got.status, got.key, got.payload, got.last);
					bad_words++;
				end
			end
		end
	end

	// Ends the run when neither channel has moved a word for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[sorted_key_table_core] ERROR");
		$finish;
	end

	initial begin : stimulus
		directed_row_t rows[$];
		reply_word_t   none;
		traffic_mode_t mode;
		skt_pkg::cmd_t cmd;
		int            counted;
		int            roll;
		int            ins_pct;
		int            srch_pct;
		int            del_pct;
		int            list_pct;

		none = '0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= skt_pkg::CMD_INSERT;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table first, then extremes, equal keys, misses and spare codes.
		rows.push_back('{skt_pkg::CMD_LIST_ASC, 16'h0000, 32'h0, 1'b1,
			'{skt_pkg::STAT_EMPTY, '0, '0, 1'b1}});
		rows.push_back('{skt_pkg::CMD_LIST_DESC, 16'h0000, 32'h0, 1'b1,
			'{skt_pkg::STAT_EMPTY, '0, '0, 1'b1}});
		rows.push_back('{skt_pkg::CMD_SEARCH, 16'h0000, 32'h0, 1'b1,
			'{skt_pkg::STAT_EMPTY, '0, '0, 1'b1}});
		rows.push_back('{skt_pkg::CMD_DELETE, 16'hFFFF, 32'hFFFFFFFF, 1'b1,
			'{skt_pkg::STAT_EMPTY, '0, '0, 1'b1}});
		rows.push_back('{skt_pkg::CMD_INSERT, 16'h8000, 32'hA5A5A5A5, 1'b1,
			'{skt_pkg::STAT_OK, 16'h8000, 32'hA5A5A5A5, 1'b1}});
		rows.push_back('{skt_pkg::CMD_INSERT, 16'hFFFF, 32'hFFFFFFFF, 1'b1,
			'{skt_pkg::STAT_OK, 16'hFFFF, 32'hFFFFFFFF, 1'b1}});
		rows.push_back('{skt_pkg::CMD_INSERT, 16'h0000, 32'h00000000, 1'b1,
			'{skt_pkg::STAT_OK, 16'h0000, 32'h00000000, 1'b1}});
		rows.push_back('{skt_pkg::CMD_INSERT, 16'h8000, 32'h5A5A5A5A, 1'b1,
			'{skt_pkg::STAT_OK, 16'h8000, 32'h5A5A5A5A, 1'b1}});
		// A key equal to the head must go to the very front.
		rows.push_back('{skt_pkg::CMD_INSERT, 16'h0000, 32'h12345678, 1'b1,
			'{skt_pkg::STAT_OK, 16'h0000, 32'h12345678, 1'b1}});
		rows.push_back('{skt_pkg::CMD_SEARCH, 16'h8000, 32'h0, 1'b0, none});
		rows.push_back('{skt_pkg::CMD_SEARCH, 16'h0000, 32'h0, 1'b0, none});
		rows.push_back('{skt_pkg::CMD_SEARCH, 16'h1234, 32'h0, 1'b1,
			'{skt_pkg::STAT_MISS, '0, '0, 1'b1}});
		rows.push_back('{skt_pkg::CMD_DELETE, 16'h7FFF, 32'h0, 1'b1,
			'{skt_pkg::STAT_MISS, '0, '0, 1'b1}});
		rows.push_back('{CMD_SPARE_A, 16'h0000, 32'h0, 1'b0, none});
		rows.push_back('{CMD_SPARE_B, 16'h8000, 32'h5A5A5A5A, 1'b0, none});
		rows.push_back('{CMD_SPARE_C, 16'hFFFF, 32'hFFFFFFFF, 1'b0, none});
		rows.push_back('{skt_pkg::CMD_LIST_ASC, 16'h0000, 32'h0, 1'b0, none});
		rows.push_back('{skt_pkg::CMD_LIST_DESC, 16'h0000, 32'h0, 1'b0, none});
		rows.push_back('{skt_pkg::CMD_DELETE, 16'h0000, 32'h0, 1'b0, none});
		rows.push_back('{skt_pkg::CMD_DELETE, 16'hFFFF, 32'h0, 1'b0, none});
		rows.push_back('{skt_pkg::CMD_DELETE, 16'h8000, 32'h0, 1'b0, none});
		rows.push_back('{skt_pkg::CMD_LIST_ASC, 16'h0000, 32'h0, 1'b0, none});
		foreach (rows[r])
			issue(rows[r].cmd, rows[r].key, rows[r].payload, rows[r].typed, rows[r].want);

		// Random traffic in phases that fill the table up, mix, and drain it.
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			case ((counted / PHASE_ITEMS) % 4)
				0:       mode = MODE_FILL;
				2:       mode = MODE_DRAIN;
				default: mode = MODE_MIXED;
			endcase
			case (mode)
				MODE_FILL: begin
					ins_pct = 85; srch_pct = 5; del_pct = 3; list_pct = 5;
				end
				MODE_DRAIN: begin
					ins_pct = 10; srch_pct = 10; del_pct = 65; list_pct = 12;
				end
				default: begin
					ins_pct = 35; srch_pct = 20; del_pct = 20; list_pct = 18;
				end
			endcase
			roll = $urandom_range(99);
			if (roll < ins_pct) begin
				cmd = skt_pkg::CMD_INSERT;
			end else if (roll < ins_pct + srch_pct) begin
				cmd = skt_pkg::CMD_SEARCH;
			end else if (roll < ins_pct + srch_pct + del_pct) begin
				cmd = skt_pkg::CMD_DELETE;
			end else if (roll < ins_pct + srch_pct + del_pct + list_pct) begin
				cmd = $urandom_range(1) ? skt_pkg::CMD_LIST_ASC : skt_pkg::CMD_LIST_DESC;
			end else begin
				cmd = skt_pkg::cmd_t'($urandom_range(CMD_SPARE_A, CMD_SPARE_C));
			end
			if (cmd == skt_pkg::CMD_SEARCH || cmd == skt_pkg::CMD_DELETE)
				issue(cmd, pick_key($urandom_range(99) < 80), $urandom(), 1'b0, none);
			else
				issue(cmd, pick_key(1'b0), $urandom(), 1'b0, none);
			if (cmd <= skt_pkg::CMD_LIST_DESC)
				counted++;
		end
		s_axis_tvalid <= 1'b0;

		// Drain what is still owed, then give stray words time to show.
		while (awaited_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
		if (bad_words == 0)
			$display("[sorted_key_table_core] OK");
		else
			$display("[sorted_key_table_core] ERROR");
		$finish;
	end

endmodule
